>>> src/cfd_pkg.sv
// Shared types and constants for the COBS frame decoder.
// Used by cobs_frame_decoder and its testbench; depends on nothing else.
`default_nettype none

package cfd_pkg;

  // Frame status codes reported on the closing result.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_UNDERRUN = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // A group opened by this code carries no implied zero after it.
  localparam logic [7:0] FullGroupCode = 8'hFF;

  // Reset value of the output capacity register.
  localparam logic [15:0] MaxOutLenReset = 16'hFFFF;

  localparam int unsigned OutTdataWidth = 32;

endpackage : cfd_pkg

`default_nettype wire

>>> src/cobs_frame_decoder.sv
// COBS frame decoder: one encoded byte in, at most one decoded result out.
// Depends on cfd_pkg for the status codes and constants.
//
//   Channel   | Direction | Handshake                    | Payload
//   ----------+-----------+------------------------------+-------------------------------
//   s_axis    | in        | s_axis_tvalid/s_axis_tready  | in_byte, has_byte, frame_end
//   m_axis    | out       | m_axis_tvalid/m_axis_tready  | out_byte, out_valid, frame_done,
//             |           |                              | status, decoded_len
//   cfg       | in        | cfg_valid_i/cfg_ready_o      | max_out_len
//
// Every input transfer is decoded in the cycle it is accepted: the frame state and the
// result register are both written at that clock edge. The only stage is the result
// register; the input is ready whenever that register is empty or its contents leave
// in the same cycle, so the block takes one byte per cycle until a stalled consumer
// holds the input back after one result. The configuration channel is always ready.
// Reset returns the frame state to the start of a frame and the capacity to 65535.
`default_nettype none

module cobs_frame_decoder
  import cfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  wire logic        s_axis_tuser,  // [0] has_byte
  input  wire logic        s_axis_tlast,  // frame_end

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [OutTdataWidth-1:0] m_axis_tdata,  // [7:0] out_byte, [9:8] status,
                                                  // [25:10] decoded_len, [31:26] zero
  output logic             m_axis_tuser,  // [0] out_valid
  output logic             m_axis_tlast,  // frame_done

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i     // max_out_len
);

  // Capacity register.
  logic [15:0] max_out_len_q;

  // Frame state.
  logic [7:0]  group_left_q, group_left_d;
  logic        expect_code_q, expect_code_d;
  logic        zero_pending_q, zero_pending_d;
  logic [15:0] byte_count_q, byte_count_d;
  status_e     committed_error_q, committed_error_d;
  status_e     group_error_q, group_error_d;
  logic        seen_byte_q, seen_byte_d;

  // Result register.
  logic        res_valid_q;
  logic [7:0]  res_byte_q;
  logic        res_has_byte_q;
  logic        res_done_q;
  status_e     res_status_q;
  logic [15:0] res_len_q;

  logic        in_accept;
  logic        emit;
  logic [7:0]  emit_byte;
  status_e     close_status;
  logic [15:0] close_len;
  logic [7:0]  group_left_dec;

  wire logic [7:0] in_byte   = s_axis_tdata;
  wire logic       has_byte  = s_axis_tuser;
  wire logic       frame_end = s_axis_tlast;

  assign s_axis_tready = !res_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign group_left_dec = (group_left_q != 8'd0) ? group_left_q - 8'd1 : 8'd0;

  // Decode one byte against the running frame state.
  always_comb begin
    group_left_d      = group_left_q;
    expect_code_d     = expect_code_q;
    zero_pending_d    = zero_pending_q;
    byte_count_d      = byte_count_q;
    committed_error_d = committed_error_q;
    group_error_d     = group_error_q;
    seen_byte_d       = seen_byte_q;
    emit              = 1'b0;
    emit_byte         = 8'd0;

    if (has_byte) begin
      seen_byte_d = 1'b1;
      if (committed_error_q == ST_OK) begin
        if (expect_code_q) begin
          // The zero implied by the previous group comes out ahead of the new code.
          if (zero_pending_q) begin
            zero_pending_d = 1'b0;
            if (byte_count_q >= max_out_len_q) begin
              committed_error_d = ST_OVERFLOW;
            end else begin
              emit         = 1'b1;
              byte_count_d = byte_count_q + 16'd1;
            end
          end
          if (committed_error_d == ST_OK) begin
            if (in_byte == 8'd0) begin
              committed_error_d = ST_INVALID;
            end else begin
              group_left_d   = in_byte - 8'd1;
              zero_pending_d = (in_byte != FullGroupCode);
              group_error_d  = ST_OK;
              expect_code_d  = (in_byte == 8'd1);
            end
          end
        end else begin
          // Data byte inside a group; errors wait until the group completes.
          group_left_d = group_left_dec;
          if (group_error_q == ST_OK) begin
            if (in_byte == 8'd0) begin
              group_error_d = ST_INVALID;
            end else if (byte_count_q >= max_out_len_q) begin
              group_error_d = ST_OVERFLOW;
            end else begin
              emit         = 1'b1;
              emit_byte    = in_byte;
              byte_count_d = byte_count_q + 16'd1;
            end
          end
          if (group_left_dec == 8'd0) begin
            expect_code_d = 1'b1;
            if (group_error_d != ST_OK) begin
              committed_error_d = group_error_d;
            end
            group_error_d = ST_OK;
          end
        end
      end
    end

    // Closing status: a committed error wins; else an unfinished group or an empty frame is an underrun.
    close_len = 16'd0;
    if (committed_error_d != ST_OK) begin
      close_status = committed_error_d;
    end else if (!seen_byte_d || !expect_code_d) begin
      close_status = ST_UNDERRUN;
    end else begin
      close_status = ST_OK;
      close_len    = byte_count_d;
    end

    if (frame_end) begin
      group_left_d      = 8'd0;
      expect_code_d     = 1'b1;
      zero_pending_d    = 1'b0;
      byte_count_d      = 16'd0;
      committed_error_d = ST_OK;
      group_error_d     = ST_OK;
      seen_byte_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_len_q <= MaxOutLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_out_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_left_q      <= 8'd0;
      expect_code_q     <= 1'b1;
      zero_pending_q    <= 1'b0;
      byte_count_q      <= 16'd0;
      committed_error_q <= ST_OK;
      group_error_q     <= ST_OK;
      seen_byte_q       <= 1'b0;
    end else if (in_accept) begin
      group_left_q      <= group_left_d;
      expect_code_q     <= expect_code_d;
      zero_pending_q    <= zero_pending_d;
      byte_count_q      <= byte_count_d;
      committed_error_q <= committed_error_d;
      group_error_q     <= group_error_d;
      seen_byte_q       <= seen_byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_accept && (emit || frame_end)) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (emit || frame_end)) begin
      res_byte_q     <= emit_byte;
      res_has_byte_q <= emit;
      res_done_q     <= frame_end;
      res_status_q   <= frame_end ? close_status : ST_OK;
      res_len_q      <= frame_end ? close_len : 16'd0;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {6'd0, res_len_q, res_status_q, res_byte_q};
  assign m_axis_tuser  = res_has_byte_q;
  assign m_axis_tlast  = res_done_q;

  // A result that does not close the frame always carries a decoded byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("non-closing result without a decoded byte");

  // A nonzero length is only reported on a clean close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_len_q != 16'd0) |-> res_done_q && (res_status_q == ST_OK))
    else $error("decoded length reported outside a clean close");

  // Inside a group there is always at least one data byte left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !expect_code_q |-> group_left_q != 8'd0)
    else $error("group open with no bytes left");

  // A committed error stays until the frame closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (committed_error_q != ST_OK) && !(in_accept && frame_end)
      |=> committed_error_q == $past(committed_error_q))
    else $error("committed error changed before frame close");

  // A held result is not overwritten while the consumer stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule : cobs_frame_decoder

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for cobs_frame_decoder: directed frames, then random phases.
// Depends on cfd_pkg for status codes and constants and on the decoder RTL itself.
// A small checker class predicts each decoded result and compares what the block delivers.
`timescale 1ns / 100ps

module testbench
  import cfd_pkg::*;
;

  localparam int unsigned RunLimitNs  = 5_000_000;
  localparam int unsigned PhaseItems  = 72;
  localparam int unsigned LongHoldCyc = 300;

  // One decoded result as the block should deliver it.
  typedef struct {
    logic [7:0]  data;
    bit          data_valid;
    bit          done;
    status_e     status;
    logic [15:0] len;
  } decoded_t;

  // Tracks the decoder's frame state and holds the decoded results still owed.
  class decode_checker;
    logic [15:0] capacity;
    logic [7:0]  group_left;
    bit          expect_code;
    bit          zero_pending;
    bit          seen_byte;
    logic [15:0] byte_count;
    status_e     committed_err;
    status_e     group_err;
    decoded_t    owed_q[$];
    int          errors;
    int          checked;
    int          closes[4];

    function new();
      capacity = MaxOutLenReset;
      errors   = 0;
      checked  = 0;
      foreach (closes[i]) closes[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      group_left    = '0;
      expect_code   = 1'b1;
      zero_pending  = 1'b0;
      seen_byte     = 1'b0;
      byte_count    = '0;
      committed_err = ST_OK;
      group_err     = ST_OK;
    endfunction

    function void set_capacity(logic [15:0] value);
      capacity = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advances the frame state by one accepted item and queues the result it causes.
    function void note_encoded(logic [7:0] data, bit has, bit fend);
      bit         emit;
      logic [7:0] out_data;
      decoded_t   r;
      emit     = 1'b0;
      out_data = 8'h00;
      if (has) begin
        seen_byte = 1'b1;
        if (committed_err == ST_OK) begin
          if (expect_code) begin
            // The zero implied by the previous group goes out ahead of the new code.
            if (zero_pending) begin
              zero_pending = 1'b0;
              if (byte_count >= capacity) begin
                committed_err = ST_OVERFLOW;
              end else begin
                emit = 1'b1;
                byte_count++;
              end
            end
            if (committed_err == ST_OK) begin
              if (data == 8'h00) begin
                committed_err = ST_INVALID;
              end else begin
                group_left   = data - 8'd1;
                zero_pending = (data != FullGroupCode);
                group_err    = ST_OK;
                expect_code  = (group_left == 0);
              end
            end
          end else begin
            if (group_left != 0) group_left--;
            if (group_err == ST_OK) begin
              if (data == 8'h00) begin
                group_err = ST_INVALID;
              end else if (byte_count >= capacity) begin
                group_err = ST_OVERFLOW;
              end else begin
                emit     = 1'b1;
                out_data = data;
                byte_count++;
              end
            end
            // Errors inside a group only count once the group is complete.
            if (group_left == 0) begin
              expect_code = 1'b1;
              if (group_err != ST_OK) committed_err = group_err;
              group_err = ST_OK;
            end
          end
        end
      end
      if (emit || fend) begin
        r.data       = out_data;
        r.data_valid = emit;
        r.done       = fend;
        r.status     = ST_OK;
        r.len        = '0;
        if (fend) begin
          if (committed_err != ST_OK) begin
            r.status = committed_err;
          end else if (!seen_byte || !expect_code) begin
            r.status = ST_UNDERRUN;
          end else begin
            r.len = byte_count;
          end
          clear_frame();
        end
        owed_q.push_back(r);
      end
    endfunction

    // Compares one delivered result with the oldest one owed.
    function void check_decoded(logic [OutTdataWidth-1:0] tdata, logic tuser, logic tlast);
      decoded_t r;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual byte=%02h valid=%0b done=%0b status=%0d len=%0d",
                 $time, tdata[7:0], tuser, tlast, tdata[9:8], tdata[25:10]);
        return;
      end
      r = owed_q.pop_front();
      checked++;
      if (r.done) closes[r.status]++;
      if (tdata[7:0] !== r.data || tuser !== r.data_valid || tlast !== r.done ||
          tdata[9:8] !== r.status || tdata[25:10] !== r.len) begin
        errors++;
        $display("%0t: result mismatch: expected byte=%02h valid=%0b done=%0b status=%0d len=%0d",
                 $time, r.data, r.data_valid, r.done, r.status, r.len);
        $display("%0t:                    actual byte=%02h valid=%0b done=%0b status=%0d len=%0d",
                 $time, tdata[7:0], tuser, tlast, tdata[9:8], tdata[25:10]);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata;   // [7:0] in_byte
  logic                     s_axis_tuser;   // [0] has_byte
  logic                     s_axis_tlast;   // frame_end
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OutTdataWidth-1:0] m_axis_tdata;   // [7:0] out_byte, [9:8] status, [25:10] decoded_len
  logic                     m_axis_tuser;   // [0] out_valid
  logic                     m_axis_tlast;   // frame_done
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [15:0]              cfg_data_i;     // max_out_len

  decode_checker board = new();
  logic [7:0]    frame_q[$];
  bit            quiet = 1'b0;
  int            sink_hold_cycles = 0;
  int            items_sent = 0;
  int            frames_sent = 0;

  always #5 clk_i = ~clk_i;

  cobs_frame_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Result side: every transfer on the output is checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_decoded(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Consumer: ready most of the time, with random stall bursts and one long hold on request.
  initial begin : sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 18);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offers one item, sometimes after a gap, and waits for its transfer.
  task automatic send_item(input logic [7:0] data, input bit has, input bit fend);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = data;
    s_axis_tuser  = has;
    s_axis_tlast  = fend;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_encoded(data, has, fend);
    if (has || fend) items_sent++;
  endtask

  // Sends frame_q as one frame, closed on its last byte or by a close item of its own.
  task automatic send_frame_bytes(input bit close_alone, input bit with_noise);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (with_noise && $urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(frame_q[i], 1'b1, !close_alone && i == frame_q.size() - 1);
    end
    if (close_alone) send_item(8'($urandom), 1'b0, 1'b1);
    frames_sent++;
  endtask

  // Builds a random frame of well-formed groups, then sometimes damages it.
  task automatic send_frame(input bit force_full);
    int groups;
    int code;
    int flaw;
    frame_q.delete();
    groups = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      if (force_full && g == 0) begin
        code = FullGroupCode;
      end else if ($urandom_range(0, 9) == 0) begin
        code = $urandom_range(13, 60);
      end else begin
        code = $urandom_range(1, 12);
      end
      frame_q.push_back(8'(code));
      repeat (code - 1) frame_q.push_back(8'($urandom_range(1, 255)));
    end
    flaw = $urandom_range(0, 7);
    if (flaw == 0) begin
      // Cut the tail off, which usually leaves the frame inside a group.
      repeat ($urandom_range(1, 3)) begin
        if (frame_q.size() > 0) void'(frame_q.pop_back());
      end
    end else if (flaw == 1 && frame_q.size() > 0) begin
      frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'h00;
    end else if (flaw == 2) begin
      // A full-size group that the frame never finishes.
      frame_q.push_back(FullGroupCode);
      repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_frame_bytes(frame_q.size() == 0 || $urandom_range(0, 1) == 1, 1'b1);
  endtask

  // Stops offering input and waits until every owed result has been delivered.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    int          phase_start;
    bit          first;
    logic [15:0] cap;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames at the reset capacity.
    frame_q.delete();
    send_frame_bytes(1'b1, 1'b0);                 // empty frame
    frame_q = '{8'h01};
    send_frame_bytes(1'b0, 1'b0);                 // lone code, trailing zero not emitted
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);                 // ignored item inside a group
    send_item(8'h22, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);                 // releases the implied zero
    send_item(8'hFF, 1'b1, 1'b1);
    frame_q = '{8'h02, 8'h41, 8'h00, 8'h05};
    send_frame_bytes(1'b0, 1'b0);                 // zero code byte
    frame_q = '{8'h03, 8'h00, 8'h07};
    send_frame_bytes(1'b0, 1'b0);                 // zero data byte, group completes
    frame_q = '{8'h04, 8'h00};
    send_frame_bytes(1'b0, 1'b0);                 // zero data byte, frame ends in group
    frame_q = '{8'hFF, 8'h80, 8'h7F};
    send_frame_bytes(1'b1, 1'b0);                 // unfinished full-size group

    // Capacity extremes.
    write_capacity(16'd0);
    frame_q = '{8'h02, 8'h80};
    send_frame_bytes(1'b0, 1'b0);                 // no room for any data byte
    write_capacity(16'd1);
    frame_q = '{8'h02, 8'h01, 8'h03, 8'h02};
    send_frame_bytes(1'b0, 1'b0);                 // implied zero hits the limit
    frame_q = '{8'h04, 8'h01, 8'h02};
    send_frame_bytes(1'b0, 1'b0);                 // group overflow replaced by underrun

    // Random phases, each with a capacity written at its start; the last one runs without idling.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       cap = MaxOutLenReset;
        1:       cap = 16'd0;
        2:       cap = 16'($urandom_range(1, 24));
        3:       cap = MaxOutLenReset;
        4:       cap = 16'($urandom_range(25, 200));
        default: cap = MaxOutLenReset;
      endcase
      write_capacity(cap);
      quiet       = (phase == 5);
      phase_start = items_sent;
      first       = 1'b1;
      while (items_sent - phase_start < PhaseItems) begin
        // The consumer holds off long enough for the input to back up.
        if (phase == 2 && first) sink_hold_cycles = LongHoldCyc;
        send_frame(phase == 3 && first);
        if (phase == 4 && first) wait_drained();
        first = 1'b0;
      end
    end

    wait_drained();
    $display("Run covered %0d encoded items in %0d frames at capacities 0 to 65535, %0d results checked.",
             items_sent, frames_sent, board.checked);
    $display("Frame closes by status: ok %0d, invalid %0d, underrun %0d, overflow %0d.",
             board.closes[ST_OK], board.closes[ST_INVALID], board.closes[ST_UNDERRUN],
             board.closes[ST_OVERFLOW]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #RunLimitNs;
    $display("Timeout with %0d results still owed.", board.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> cobs_frame_decoder.f
src/cfd_pkg.sv
src/cobs_frame_decoder.sv
verif/testbench.sv
